### design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i, reset on rst_ni.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define TSW_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("tsw assertion failed");

// Same, with a caller supplied message.
`define TSW_ASSERT_MSG(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

`endif

### design/tsw_pkg.sv
// ---------------------------------------------------------------------------
// tsw_pkg
// Types and constants of the three source collision watchdog.
// ---------------------------------------------------------------------------
package tsw_pkg;

  localparam int unsigned NumSources = 3;
  localparam int unsigned CntW       = 8;

  localparam logic [CntW-1:0] CntMax       = '1;
  localparam logic [CntW-1:0] TimeoutReset = 8'd15;  // 15 ticks

  typedef enum logic [1:0] {
    ActReport = 2'd0,
    ActTick   = 2'd1,
    ActStart  = 2'd2,
    ActStop   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    CauseNone         = 3'd0,
    CauseCollJoint    = 3'd1,
    CauseCollFinger   = 3'd2,
    CauseCollForce    = 3'd3,
    CauseTimeoutJoint = 3'd4,
    CauseTimeoutFinger = 3'd5,
    CauseTimeoutForce = 3'd6
  } cause_e;

  // Captured input word.
  typedef struct packed {
    logic [1:0]            action;
    logic [1:0]            source;
    logic                  collision_flag;
    logic [NumSources-1:0] enables;  // bit 0 joint, 1 finger, 2 force
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic       stop_raised;
    logic [2:0] cause;
    logic       stop_detector;
    logic       start_detector;
    logic       heartbeat_valid;
    logic       heartbeat;
    logic       armed;
  } res_word_t;

endpackage

### design/three_source_collision_watchdog.sv
// ---------------------------------------------------------------------------
// three_source_collision_watchdog
// Latching watchdog over the joint, finger and force collision detectors.
// ---------------------------------------------------------------------------
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------
//  in      | input     | in_valid_i / in_ready_o    | action, source, flags
//  out     | output    | out_valid_o / out_ready_i  | stop, cause, requests, hb
//  cfg     | input     | cfg_we_i (no wait)         | cfg_wdata_i = timeout
//
//  One word in, one word out, one word per cycle sustained unless the
//  output stalls. An input register feeds the state update, whose result
//  lands in the output register; it is a few 8-bit increments and compares.
//  Reset clears the armed flag, the source enables and the silence counters
//  and loads the timeout with 15 ticks. A stalled output holds the output
//  register; the input register then fills and in_ready_o drops.
//
`include "assert_macros.svh"

module three_source_collision_watchdog (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input channel
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] action_i,
  input  logic [1:0] source_i,
  input  logic       collision_flag_i,
  input  logic       enable_joint_i,
  input  logic       enable_finger_i,
  input  logic       enable_force_i,
  // output channel
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       stop_raised_o,
  output logic [2:0] cause_o,
  output logic       stop_detector_o,
  output logic       start_detector_o,
  output logic       heartbeat_valid_o,
  output logic       heartbeat_o,
  output logic       armed_o,
  // configuration
  input  logic       cfg_we_i,
  input  logic [tsw_pkg::CntW-1:0] cfg_wdata_i
);
  import tsw_pkg::*;

  // Input register
  logic     in_valid_q;
  in_word_t in_q;
  logic     advance;

  // Watchdog state
  logic                  armed_q, armed_d;
  logic [NumSources-1:0] en_q, en_d;
  logic [CntW-1:0]       cnt_q [NumSources];
  logic [CntW-1:0]       cnt_d [NumSources];
  logic [CntW-1:0]       timeout_q;

  // Output register
  logic      out_valid_q;
  res_word_t res_q, res_d;

  // Report hit and tick scan helpers
  logic [NumSources:0] src_en;   // padded so the unused source code reads 0
  logic                hit;
  logic                found;

  // The processing stage fires when the output register is free or draining.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q.action         <= action_i;
      in_q.source         <= source_i;
      in_q.collision_flag <= collision_flag_i;
      in_q.enables        <= {enable_force_i, enable_finger_i, enable_joint_i};
    end
  end

  // Next state and result for the word in the input register.
  assign src_en = {1'b0, en_q};
  assign hit    = armed_q && src_en[in_q.source];

  always_comb begin
    armed_d = armed_q;
    en_d    = en_q;
    cnt_d   = cnt_q;
    res_d   = '0;
    found   = 1'b0;
    case (action_e'(in_q.action))
      ActReport: begin
        // A report from an enabled source while armed clears its counter, even when
        // it is the collision that disarms us.
        for (int i = 0; i < NumSources; i++) begin
          if (hit && in_q.source == 2'(i)) begin
            cnt_d[i] = '0;
          end
        end
        if (hit && in_q.collision_flag) begin
          armed_d             = 1'b0;
          res_d.stop_raised   = 1'b1;
          res_d.cause         = 3'(CauseCollJoint) + 3'(in_q.source);
          res_d.stop_detector = 1'b1;
        end
      end
      ActTick: begin
        for (int i = 0; i < NumSources; i++) begin
          if (en_q[i] && cnt_q[i] != CntMax) begin
            cnt_d[i] = cnt_q[i] + 1'b1;
          end
        end
        // Joint first, then finger, then force: first timeout wins.
        if (armed_q) begin
          for (int i = 0; i < NumSources; i++) begin
            if (!found && en_q[i] && cnt_d[i] > timeout_q) begin
              found               = 1'b1;
              armed_d             = 1'b0;
              res_d.stop_raised   = 1'b1;
              res_d.cause         = 3'(CauseTimeoutJoint) + 3'(i);
              res_d.stop_detector = 1'b1;
            end
          end
        end
        res_d.heartbeat_valid = 1'b1;
        res_d.heartbeat       = !armed_d;
      end
      ActStart: begin
        en_d = in_q.enables;
        for (int i = 0; i < NumSources; i++) begin
          cnt_d[i] = '0;
        end
        armed_d              = 1'b1;
        res_d.start_detector = 1'b1;
      end
      ActStop: begin
        armed_d             = 1'b0;
        res_d.stop_detector = 1'b1;
      end
      default: begin
        armed_d = armed_q;
      end
    endcase
    res_d.armed = armed_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b0;
      en_q    <= '0;
      for (int i = 0; i < NumSources; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (advance) begin
      armed_q <= armed_d;
      en_q    <= en_d;
      cnt_q   <= cnt_d;
    end
  end

  // Timeout register; to be written only while the block is idle, which the block itself does not enforce.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign stop_raised_o     = res_q.stop_raised;
  assign cause_o           = res_q.cause;
  assign stop_detector_o   = res_q.stop_detector;
  assign start_detector_o  = res_q.start_detector;
  assign heartbeat_valid_o = res_q.heartbeat_valid;
  assign heartbeat_o       = res_q.heartbeat;
  assign armed_o           = res_q.armed;

  // A raised stop always disarms, names a cause and asks for a detector stop.
  `TSW_ASSERT(a_stop_consistent, out_valid_o && stop_raised_o |-> !armed_o && stop_detector_o && cause_o != 3'(CauseNone))

  // The armed bit of a fresh result matches the armed state that the update left behind.
  `TSW_ASSERT_MSG(a_armed_tracks_state, advance |=> armed_o == armed_q, "armed result out of step with state")

  // A heartbeat is only shown on tick results and mirrors the disarmed state.
  `TSW_ASSERT(a_heartbeat, out_valid_o && heartbeat_valid_o |-> heartbeat_o == !armed_o)

endmodule

### verif/tb_three_source_collision_watchdog.sv
// ---------------------------------------------------------------------------
// tb_three_source_collision_watchdog
// Self-checking bench for the three source collision watchdog: an in-bench
// predictor tracks the armed flag, the source enables and the silence
// counters, and every result word is compared field by field in order.
// ---------------------------------------------------------------------------
module tb_three_source_collision_watchdog;
  import tsw_pkg::*;

  localparam int unsigned IdlePct    = 31;    // idle chance per cycle, in percent
  localparam int unsigned RandWords  = 350;   // random words that the block acts on
  localparam int unsigned RandPhases = 5;
  localparam int unsigned MaxPrints  = 100;

  // DUT ports, all driven from time zero
  logic             clk_i             = 1'b0;
  logic             rst_ni            = 1'b0;
  logic             in_valid_i        = 1'b0;
  logic             in_ready_o;
  logic [1:0]       action_i          = '0;
  logic [1:0]       source_i          = '0;
  logic             collision_flag_i  = 1'b0;
  logic             enable_joint_i    = 1'b0;
  logic             enable_finger_i   = 1'b0;
  logic             enable_force_i    = 1'b0;
  logic             out_valid_o;
  logic             out_ready_i       = 1'b0;
  logic             stop_raised_o;
  logic [2:0]       cause_o;
  logic             stop_detector_o;
  logic             start_detector_o;
  logic             heartbeat_valid_o;
  logic             heartbeat_o;
  logic             armed_o;
  logic             cfg_we_i          = 1'b0;
  logic [CntW-1:0]  cfg_wdata_i       = '0;

  // Predictor state: mirror of the watchdog after each accepted word
  bit                   wd_armed;
  logic [NumSources-1:0] wd_enables;
  logic [CntW-1:0]      wd_silence [NumSources];
  logic [CntW-1:0]      wd_timeout;

  res_word_t   pending_results [$];  // predicted words, oldest first
  int unsigned error_count  = 0;
  int unsigned result_count = 0;
  bit          no_idle      = 1'b0;  // both sides run flat out while set

  three_source_collision_watchdog dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .action_i          (action_i),
    .source_i          (source_i),
    .collision_flag_i  (collision_flag_i),
    .enable_joint_i    (enable_joint_i),
    .enable_finger_i   (enable_finger_i),
    .enable_force_i    (enable_force_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .stop_raised_o     (stop_raised_o),
    .cause_o           (cause_o),
    .stop_detector_o   (stop_detector_o),
    .start_detector_o  (start_detector_o),
    .heartbeat_valid_o (heartbeat_valid_o),
    .heartbeat_o       (heartbeat_o),
    .armed_o           (armed_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hard stop in case a handshake hangs. Slowest sane run is far below this.
  initial begin
    #3_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MaxPrints) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  // Predicts the result word of one input word and advances the mirror.
  function automatic res_word_t predict_watchdog(input in_word_t w);
    res_word_t r;
    bit        fired;
    r     = '0;
    fired = 1'b0;
    case (w.action)
      ActReport: begin
        // source 3, disarmed or disabled source: ignored
        if (w.source < NumSources && wd_armed && wd_enables[w.source]) begin
          if (w.collision_flag) begin
            wd_armed        = 1'b0;
            r.stop_raised   = 1'b1;
            r.cause         = 3'(CauseCollJoint) + 3'(w.source);
            r.stop_detector = 1'b1;
          end
          // cleared even when the report disarmed
          wd_silence[w.source] = '0;
        end
      end
      ActTick: begin
        // counters run while disarmed too, saturating
        for (int i = 0; i < NumSources; i++) begin
          if (wd_enables[i] && wd_silence[i] != CntMax)
            wd_silence[i] = wd_silence[i] + 8'd1;
        end
        // only the first expired source (joint, finger, force) counts
        if (wd_armed) begin
          for (int i = 0; i < NumSources; i++) begin
            if (!fired && wd_enables[i] && wd_silence[i] > wd_timeout) begin
              fired           = 1'b1;
              wd_armed        = 1'b0;
              r.stop_raised   = 1'b1;
              r.cause         = 3'(CauseTimeoutJoint) + 3'(i);
              r.stop_detector = 1'b1;
            end
          end
        end
        r.heartbeat_valid = 1'b1;
        r.heartbeat       = !wd_armed;
      end
      ActStart: begin
        // re-arms even when already armed
        wd_enables = w.enables;
        for (int i = 0; i < NumSources; i++) wd_silence[i] = '0;
        r.start_detector = 1'b1;
        wd_armed         = 1'b1;
      end
      default: begin
        // stop requests a detector stop even while disarmed
        r.stop_detector = 1'b1;
        wd_armed        = 1'b0;
      end
    endcase
    r.armed = wd_armed;
    return r;
  endfunction

  // Sends one input word, with random idle cycles ahead of it. Valid is held
  // until the word is taken. acted is low for reports the block ignores.
  task automatic send_word(input action_e act, input logic [1:0] src, input logic coll,
                           input logic [2:0] en, output bit acted);
    in_word_t w;
    w.action         = act;
    w.source         = src;
    w.collision_flag = coll;
    w.enables        = en;
    @(negedge clk_i);
    while (!no_idle && $urandom_range(0, 99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    action_i         <= w.action;
    source_i         <= w.source;
    collision_flag_i <= w.collision_flag;
    enable_joint_i   <= w.enables[0];
    enable_finger_i  <= w.enables[1];
    enable_force_i   <= w.enables[2];
    in_valid_i       <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    acted = !(act == ActReport &&
              !(src < NumSources && wd_armed && wd_enables[src]));
    pending_results.push_back(predict_watchdog(w));
  endtask

  // Drops valid and waits until every predicted word has come back.
  task automatic drain_results;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);  // input and output registers, plus margin
  endtask

  // Timeout register is only touched with the pipe empty.
  task automatic write_timeout(input logic [CntW-1:0] value);
    drain_results();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= 8'($urandom());
    wd_timeout = value;
  endtask

  // Result side: random stalls unless no_idle is set, one assignment per falling edge.
  always @(negedge clk_i) begin
    out_ready_i <= no_idle || ($urandom_range(0, 99) >= IdlePct);
  end

  // Result checker: each accepted word against the oldest prediction.
  always @(posedge clk_i) begin : check_results
    res_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      result_count++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing pending", result_count));
      end else begin
        want = pending_results.pop_front();
        if (stop_raised_o !== want.stop_raised)
          report_mismatch($sformatf("result %0d stop_raised got %b want %b",
                                    result_count, stop_raised_o, want.stop_raised));
        if (cause_o !== want.cause)
          report_mismatch($sformatf("result %0d cause got %0d want %0d",
                                    result_count, cause_o, want.cause));
        if (stop_detector_o !== want.stop_detector)
          report_mismatch($sformatf("result %0d stop_detector got %b want %b",
                                    result_count, stop_detector_o, want.stop_detector));
        if (start_detector_o !== want.start_detector)
          report_mismatch($sformatf("result %0d start_detector got %b want %b",
                                    result_count, start_detector_o, want.start_detector));
        if (heartbeat_valid_o !== want.heartbeat_valid)
          report_mismatch($sformatf("result %0d heartbeat_valid got %b want %b",
                                    result_count, heartbeat_valid_o, want.heartbeat_valid));
        if (heartbeat_o !== want.heartbeat)
          report_mismatch($sformatf("result %0d heartbeat got %b want %b",
                                    result_count, heartbeat_o, want.heartbeat));
        if (armed_o !== want.armed)
          report_mismatch($sformatf("result %0d armed got %b want %b",
                                    result_count, armed_o, want.armed));
      end
    end
  end

  // Short hand-picked sequence at the reset timeout, then timeout 0.
  task automatic test_directed;
    bit acted;
    send_word(ActReport, 2'd0, 1'b1, 3'b111, acted);  // report while disarmed
    send_word(ActTick,   2'd3, 1'b1, 3'b111, acted);  // tick while disarmed, heartbeat 1
    send_word(ActStop,   2'd2, 1'b0, 3'b000, acted);  // stop while disarmed
    send_word(ActStart,  2'd0, 1'b0, 3'b111, acted);
    send_word(ActReport, 2'd3, 1'b1, 3'b000, acted);  // source 3 matches nothing
    send_word(ActReport, 2'd0, 1'b0, 3'b000, acted);
    send_word(ActTick,   2'd1, 1'b0, 3'b000, acted);
    send_word(ActReport, 2'd1, 1'b1, 3'b000, acted);  // finger collision
    send_word(ActTick,   2'd0, 1'b0, 3'b000, acted);  // counters keep going disarmed
    send_word(ActStart,  2'd0, 1'b0, 3'b101, acted);  // finger left out
    send_word(ActReport, 2'd1, 1'b1, 3'b000, acted);  // disabled source, ignored
    send_word(ActReport, 2'd2, 1'b1, 3'b010, acted);  // force collision
    send_word(ActStart,  2'd0, 1'b0, 3'b001, acted);
    send_word(ActTick,   2'd0, 1'b0, 3'b000, acted);
    send_word(ActStart,  2'd0, 1'b0, 3'b111, acted);  // start while armed
    send_word(ActReport, 2'd0, 1'b1, 3'b000, acted);  // joint collision
    send_word(ActStart,  2'd2, 1'b1, 3'b000, acted);  // armed, nothing enabled
    send_word(ActTick,   2'd0, 1'b0, 3'b000, acted);
    send_word(ActStop,   2'd0, 1'b0, 3'b111, acted);

    // timeout 0: every enabled source expires on the first tick, joint wins
    write_timeout(8'd0);
    send_word(ActStart,  2'd0, 1'b0, 3'b111, acted);
    send_word(ActTick,   2'd0, 1'b0, 3'b000, acted);
    send_word(ActStart,  2'd0, 1'b0, 3'b110, acted);
    send_word(ActTick,   2'd0, 1'b0, 3'b000, acted);  // finger first now
  endtask

  // Long tick runs at the small and large ends of the timeout.
  task automatic test_timeout_extremes;
    bit acted;
    // 1: joint kept alive by reports, finger expires on the second tick
    write_timeout(8'd1);
    send_word(ActStart,  2'd0, 1'b0, 3'b011, acted);
    send_word(ActTick,   2'd0, 1'b0, 3'b000, acted);
    send_word(ActReport, 2'd0, 1'b0, 3'b000, acted);
    send_word(ActTick,   2'd0, 1'b0, 3'b000, acted);

    // 254: force alone, expires only once the counter saturates
    write_timeout(8'd254);
    send_word(ActStart, 2'd1, 1'b0, 3'b100, acted);
    repeat (257) send_word(ActTick, 2'($urandom()), 1'($urandom()), 3'($urandom()), acted);

    // 255: saturated counters can never pass it
    write_timeout(8'd255);
    send_word(ActStart, 2'd0, 1'b0, 3'b111, acted);
    repeat (260) send_word(ActTick, 2'($urandom()), 1'($urandom()), 3'($urandom()), acted);
    send_word(ActReport, 2'd2, 1'b1, 3'b000, acted);
  endtask

  // Mostly well-formed traffic: starts, ticks and reports from enabled
  // sources, with stray sources, disarmed reports and stops mixed in.
  task automatic test_random_traffic;
    bit              acted;
    int unsigned     useful;
    int unsigned     pick;
    action_e         act;
    logic [1:0]      src;
    logic            coll;
    logic [2:0]      en;
    logic [CntW-1:0] tmo;
    for (int p = 0; p < RandPhases; p++) begin
      case (p)
        0:       tmo = 8'($urandom_range(1, 4));
        1:       tmo = 8'($urandom_range(5, 16));
        2:       tmo = 8'($urandom_range(0, 255));
        3:       tmo = 8'd1;
        default: tmo = 8'($urandom_range(2, 40));
      endcase
      write_timeout(tmo);
      no_idle = (p == 2);  // one long stretch with no stalls on either side
      useful  = 0;
      while (useful < RandWords / RandPhases) begin
        pick = $urandom_range(0, 99);
        src  = 2'($urandom());
        coll = 1'($urandom());
        en   = 3'($urandom());
        if (pick < 8) begin
          act = ActStart;
        end else if (pick < 11) begin
          act = ActStop;
        end else if (pick < 55) begin
          act = ActTick;
        end else begin
          act  = ActReport;
          coll = ($urandom_range(0, 99) < 6);
          // mostly reports from a source that is listened to
          if (wd_enables != '0 && $urandom_range(0, 99) < 85) begin
            do src = 2'($urandom_range(0, 2)); while (!wd_enables[src]);
          end
        end
        send_word(act, src, coll, en, acted);
        if (acted) useful++;
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    wd_armed   = 1'b0;
    wd_enables = '0;
    for (int i = 0; i < NumSources; i++) wd_silence[i] = '0;
    wd_timeout = TimeoutReset;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_timeout_extremes();
    test_random_traffic();

    drain_results();
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
